>>> src/small_matrix_inverse_core_defines.svh
// ----------------------------------------------------------------------------
// Small matrix inverse: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_INVERSE_CORE_DEFINES_SVH
`define SMALL_MATRIX_INVERSE_CORE_DEFINES_SVH

// Same-cycle implication, off during reset
`define SMI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("small matrix inverse: check failed");

// Next-cycle implication, off during reset
`define SMI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("small matrix inverse: check failed");

`endif

>>> src/smi_pkg.sv
// ----------------------------------------------------------------------------
// Small matrix inverse package
// Sizes, register indexes, controller states, command and status groups,
// and the permutation table used for the determinant expansion.
// ----------------------------------------------------------------------------
`default_nettype none

package smi_pkg;

   localparam int MAX_DIM     = 4;
   localparam int FRAC_BITS   = 16;
   localparam int ELEM_W      = 32;
   localparam int THR_W       = 32;
   localparam int DIM_W       = 3;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = 5;
   localparam int ACC_W       = 128;   // product of up to four elements
   localparam int WIDE_W      = 132;   // signed sums, divider operands
   localparam int DET_W       = 64;
   localparam int PERM_W      = 5;
   localparam int PERM_LAST   = 23;
   localparam int BIT_W       = 8;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PERM,
      ST_READ,
      ST_LATCH,
      ST_MUL,
      ST_ACCUM,
      ST_DET_ABS,
      ST_DET_ROUND,
      ST_DET_SAT,
      ST_DET_TEST,
      ST_EMIT_SING,
      ST_DIV_SETUP,
      ST_DIV,
      ST_EMIT
   } smi_state_type;

   typedef struct packed {
      logic              store_we;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              acc_init;
      logic              acc_par;
      logic              elem_latch;
      logic              mul_pp;
      logic [1:0]        limb;
      logic              mul_prod;
      logic              mul_fin;
      logic              sum_clear;
      logic              sum_add;
      logic              det_abs;
      logic              det_round;
      logic              det_sat;
      logic              div_setup;
      logic              cof_par;
      logic              div_step;
      logic              emit;
      logic              emit_sing;
      logic              emit_last;
      logic [DIM_W-1:0]  dim;
   } smi_cmd_type;

   typedef struct packed {
      logic sing;
      logic out_free;
   } smi_status_type;

   typedef struct packed {
      logic            odd;
      logic [3:0][1:0] col;
   } smi_perm_type;

   function automatic smi_perm_type mk_perm(logic odd, logic [1:0] a, logic [1:0] b,
                                            logic [1:0] c, logic [1:0] d);
      smi_perm_type p;
      p.odd    = odd;
      p.col[0] = a;
      p.col[1] = b;
      p.col[2] = c;
      p.col[3] = d;
      return p;
   endfunction

   // Permutations of four columns in lexicographic order, with parity
   function automatic smi_perm_type perm_entry(logic [PERM_W-1:0] idx);
      smi_perm_type p;
      unique case (idx)
         5'd0:    p = mk_perm(1'b0, 2'd0, 2'd1, 2'd2, 2'd3);
         5'd1:    p = mk_perm(1'b1, 2'd0, 2'd1, 2'd3, 2'd2);
         5'd2:    p = mk_perm(1'b1, 2'd0, 2'd2, 2'd1, 2'd3);
         5'd3:    p = mk_perm(1'b0, 2'd0, 2'd2, 2'd3, 2'd1);
         5'd4:    p = mk_perm(1'b0, 2'd0, 2'd3, 2'd1, 2'd2);
         5'd5:    p = mk_perm(1'b1, 2'd0, 2'd3, 2'd2, 2'd1);
         5'd6:    p = mk_perm(1'b1, 2'd1, 2'd0, 2'd2, 2'd3);
         5'd7:    p = mk_perm(1'b0, 2'd1, 2'd0, 2'd3, 2'd2);
         5'd8:    p = mk_perm(1'b0, 2'd1, 2'd2, 2'd0, 2'd3);
         5'd9:    p = mk_perm(1'b1, 2'd1, 2'd2, 2'd3, 2'd0);
         5'd10:   p = mk_perm(1'b1, 2'd1, 2'd3, 2'd0, 2'd2);
         5'd11:   p = mk_perm(1'b0, 2'd1, 2'd3, 2'd2, 2'd0);
         5'd12:   p = mk_perm(1'b0, 2'd2, 2'd0, 2'd1, 2'd3);
         5'd13:   p = mk_perm(1'b1, 2'd2, 2'd0, 2'd3, 2'd1);
         5'd14:   p = mk_perm(1'b1, 2'd2, 2'd1, 2'd0, 2'd3);
         5'd15:   p = mk_perm(1'b0, 2'd2, 2'd1, 2'd3, 2'd0);
         5'd16:   p = mk_perm(1'b0, 2'd2, 2'd3, 2'd0, 2'd1);
         5'd17:   p = mk_perm(1'b1, 2'd2, 2'd3, 2'd1, 2'd0);
         5'd18:   p = mk_perm(1'b1, 2'd3, 2'd0, 2'd1, 2'd2);
         5'd19:   p = mk_perm(1'b0, 2'd3, 2'd0, 2'd2, 2'd1);
         5'd20:   p = mk_perm(1'b0, 2'd3, 2'd1, 2'd0, 2'd2);
         5'd21:   p = mk_perm(1'b1, 2'd3, 2'd1, 2'd2, 2'd0);
         5'd22:   p = mk_perm(1'b1, 2'd3, 2'd2, 2'd0, 2'd1);
         5'd23:   p = mk_perm(1'b0, 2'd3, 2'd2, 2'd1, 2'd0);
         default: p = mk_perm(1'b0, 2'd0, 2'd1, 2'd2, 2'd3);
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

>>> src/smi_controller.sv
// ----------------------------------------------------------------------------
// Small matrix inverse controller
// Sequences the load, the permutation-sum determinant, the per-element
// cofactor and division passes, and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module smi_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [smi_pkg::DIM_W-1:0]     dim_n,
   input  smi_pkg::smi_status_type       status,
   output smi_pkg::smi_cmd_type          cmd
);

   localparam logic [smi_pkg::BIT_W-1:0]  DIV_LAST  = smi_pkg::BIT_W'(smi_pkg::WIDE_W - 1);
   localparam logic [smi_pkg::PERM_W-1:0] PERM_LAST = smi_pkg::PERM_W'(smi_pkg::PERM_LAST);

   smi_pkg::smi_state_type state_ff, state_in;

   logic [smi_pkg::COUNT_W-1:0] load_count_ff, load_count_in;
   logic [smi_pkg::DIM_W-1:0]   n_ff, n_in;
   logic [smi_pkg::PERM_W-1:0]  p_ff, p_in;
   logic [1:0]                  i_ff, i_in;
   logic [2:0]                  j_ff, j_in;
   logic [smi_pkg::BIT_W-1:0]   bit_ff, bit_in;
   logic [1:0]                  r_ff, r_in;
   logic [1:0]                  c_ff, c_in;
   logic                        cof_ff, cof_in;

   logic [smi_pkg::COUNT_W-1:0] need;
   logic [smi_pkg::COUNT_W-1:0] count_plus;
   logic                        load_done;
   logic                        accept;
   logic [smi_pkg::DIM_W-1:0]   k;
   smi_pkg::smi_perm_type       perm;
   logic                        perm_ok;
   logic                        perm_last;
   logic [1:0]                  col_sel;
   logic [1:0]                  row_idx;
   logic [1:0]                  col_idx;
   logic [4:0]                  addr_full;
   logic                        last_elem;
   logic                        last_r;
   logic                        last_c;

   // Decode load progress, submatrix size and element address
   always_comb begin
      need       = {2'b00, dim_n} * {2'b00, dim_n};
      count_plus = load_count_ff + 5'd1;
      load_done  = (count_plus >= need);
      accept     = req_valid && (state_ff == smi_pkg::ST_LOAD);
      k          = cof_ff ? (n_ff - 3'd1) : n_ff;
      perm       = smi_pkg::perm_entry(p_ff);
      perm_ok    = 1'b1;
      for (int e = 0; e < 4; e++) begin
         if ((3'(e) >= k) && (perm.col[e] != 2'(e))) begin
            perm_ok = 1'b0;
         end
      end
      perm_last  = (p_ff == PERM_LAST);
      col_sel    = perm.col[i_ff];
      row_idx    = i_ff + {1'b0, (cof_ff && (i_ff >= c_ff))};
      col_idx    = col_sel + {1'b0, (cof_ff && (col_sel >= r_ff))};
      addr_full  = {3'b000, row_idx} * {2'b00, n_ff} + {3'b000, col_idx};
      last_elem  = ({1'b0, i_ff} == (k - 3'd1));
      last_r     = ({1'b0, r_ff} == (n_ff - 3'd1));
      last_c     = ({1'b0, c_ff} == (n_ff - 3'd1));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smi_pkg::ST_LOAD: begin
            if (accept && load_done) state_in = smi_pkg::ST_PERM;
         end
         smi_pkg::ST_PERM: begin
            if (perm_ok) begin
               state_in = (k == 3'd0) ? smi_pkg::ST_ACCUM : smi_pkg::ST_READ;
            end else if (perm_last) begin
               state_in = cof_ff ? smi_pkg::ST_DIV_SETUP : smi_pkg::ST_DET_ABS;
            end
         end
         smi_pkg::ST_READ:  state_in = smi_pkg::ST_LATCH;
         smi_pkg::ST_LATCH: state_in = smi_pkg::ST_MUL;
         smi_pkg::ST_MUL: begin
            if (j_ff == 3'd4) state_in = last_elem ? smi_pkg::ST_ACCUM : smi_pkg::ST_READ;
         end
         smi_pkg::ST_ACCUM: begin
            if (perm_last) begin
               state_in = cof_ff ? smi_pkg::ST_DIV_SETUP : smi_pkg::ST_DET_ABS;
            end else begin
               state_in = smi_pkg::ST_PERM;
            end
         end
         smi_pkg::ST_DET_ABS:   state_in = smi_pkg::ST_DET_ROUND;
         smi_pkg::ST_DET_ROUND: state_in = smi_pkg::ST_DET_SAT;
         smi_pkg::ST_DET_SAT:   state_in = smi_pkg::ST_DET_TEST;
         smi_pkg::ST_DET_TEST: begin
            state_in = status.sing ? smi_pkg::ST_EMIT_SING : smi_pkg::ST_PERM;
         end
         smi_pkg::ST_EMIT_SING: begin
            if (status.out_free) state_in = smi_pkg::ST_LOAD;
         end
         smi_pkg::ST_DIV_SETUP: state_in = smi_pkg::ST_DIV;
         smi_pkg::ST_DIV: begin
            if (bit_ff == DIV_LAST) state_in = smi_pkg::ST_EMIT;
         end
         smi_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = (last_r && last_c) ? smi_pkg::ST_LOAD : smi_pkg::ST_PERM;
            end
         end
         default: state_in = smi_pkg::ST_LOAD;
      endcase
   end

   // Commands and counter updates
   always_comb begin
      cmd           = '0;
      cmd.rd_addr   = addr_full[smi_pkg::ADDR_W-1:0];
      cmd.wr_addr   = load_count_ff[smi_pkg::ADDR_W-1:0];
      cmd.acc_par   = perm.odd;
      cmd.limb      = 2'(3'd3 - j_ff);
      cmd.cof_par   = r_ff[0] ^ c_ff[0];
      cmd.dim       = n_ff;
      req_stall     = 1'b1;
      load_count_in = load_count_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      bit_in        = bit_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      cof_in        = cof_ff;
      unique case (state_ff)
         smi_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            if (accept) begin
               cmd.store_we = 1'b1;
               if (load_done) begin
                  load_count_in = '0;
                  n_in          = dim_n;
                  p_in          = '0;
                  cof_in        = 1'b0;
                  cmd.sum_clear = 1'b1;
               end else begin
                  load_count_in = count_plus;
               end
            end
         end
         smi_pkg::ST_PERM: begin
            if (perm_ok) begin
               cmd.acc_init = 1'b1;
               i_in         = '0;
            end else if (!perm_last) begin
               p_in = p_ff + 5'd1;
            end
         end
         smi_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            j_in      = '0;
         end
         smi_pkg::ST_LATCH: cmd.elem_latch = 1'b1;
         smi_pkg::ST_MUL: begin
            if (j_ff == 3'd4) begin
               cmd.mul_fin = 1'b1;
               if (!last_elem) i_in = i_ff + 2'd1;
            end else begin
               cmd.mul_pp   = 1'b1;
               cmd.mul_prod = (j_ff != 3'd0);
               j_in         = j_ff + 3'd1;
            end
         end
         smi_pkg::ST_ACCUM: begin
            cmd.sum_add = 1'b1;
            if (!perm_last) p_in = p_ff + 5'd1;
         end
         smi_pkg::ST_DET_ABS:   cmd.det_abs   = 1'b1;
         smi_pkg::ST_DET_ROUND: cmd.det_round = 1'b1;
         smi_pkg::ST_DET_SAT:   cmd.det_sat   = 1'b1;
         smi_pkg::ST_DET_TEST: begin
            if (!status.sing) begin
               r_in          = '0;
               c_in          = '0;
               p_in          = '0;
               cof_in        = 1'b1;
               cmd.sum_clear = 1'b1;
            end
         end
         smi_pkg::ST_EMIT_SING: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sing = 1'b1;
               cmd.emit_last = 1'b1;
            end
         end
         smi_pkg::ST_DIV_SETUP: begin
            cmd.div_setup = 1'b1;
            bit_in        = '0;
         end
         smi_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            bit_in       = bit_ff + 8'd1;
         end
         smi_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = last_r && last_c;
               if (!(last_r && last_c)) begin
                  p_in          = '0;
                  cmd.sum_clear = 1'b1;
                  if (last_c) begin
                     c_in = '0;
                     r_in = r_ff + 2'd1;
                  end else begin
                     c_in = c_ff + 2'd1;
                  end
               end
            end
         end
         default: req_stall = 1'b1;
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= smi_pkg::ST_LOAD;
         load_count_ff <= '0;
         n_ff          <= 3'd1;
         p_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         bit_ff        <= '0;
         r_ff          <= '0;
         c_ff          <= '0;
         cof_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         n_ff          <= n_in;
         p_ff          <= p_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         bit_ff        <= bit_in;
         r_ff          <= r_in;
         c_ff          <= c_in;
         cof_ff        <= cof_in;
      end
   end

endmodule

`default_nettype wire

>>> src/smi_datapath.sv
// ----------------------------------------------------------------------------
// Small matrix inverse datapath
// Element store, limb-serial product unit, wide signed accumulator,
// determinant rounding and clipping, restoring divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module smi_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  smi_pkg::smi_cmd_type                cmd,
   output smi_pkg::smi_status_type             status,
   input  logic signed [smi_pkg::ELEM_W-1:0]   req_element_value,
   input  logic [smi_pkg::THR_W-1:0]           threshold,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [smi_pkg::ELEM_W-1:0]   rsp_inverse_value,
   output logic signed [smi_pkg::DET_W-1:0]    rsp_determinant,
   output logic                                rsp_singular,
   output logic                                rsp_saturated,
   output logic                                rsp_last_result
);

   localparam int W  = smi_pkg::WIDE_W;
   localparam int AW = smi_pkg::ACC_W;
   localparam int EW = smi_pkg::ELEM_W;
   localparam int DW = smi_pkg::DET_W;
   localparam int F  = smi_pkg::FRAC_BITS;

   localparam logic [W-1:0]  HALF_ONE = W'(1) << (F - 1);
   localparam logic [W-1:0]  HALF_TWO = W'(1) << (2 * F - 1);
   localparam logic [W-1:0]  DET_POS  = (W'(1) << (DW - 1)) - W'(1);
   localparam logic [W-1:0]  DET_NEG  = W'(1) << (DW - 1);
   localparam logic [EW-1:0] INV_POS  = (EW'(1) << (EW - 1)) - EW'(1);
   localparam logic [EW-1:0] INV_NEG  = EW'(1) << (EW - 1);

   logic [EW-1:0] store_mem [smi_pkg::STORE_DEPTH];
   logic [EW-1:0] rdata_ff;

   logic [EW-1:0]   emag_ff;
   logic [AW-1:0]   acc_mag_ff;
   logic            acc_neg_ff;
   logic [2*EW-1:0] pp_ff;
   logic [AW-1:0]   prod_ff;
   logic [W-1:0]    sum_ff;
   logic            dneg_ff;
   logic [W-1:0]    dmag_ff;
   logic [W-1:0]    qmag_ff;
   logic [DW-1:0]   detbits_ff;
   logic            dclip_ff;
   logic            sing_ff;
   logic            cneg_ff;
   logic [W-1:0]    num_ff;
   logic [W-1:0]    den_ff;
   logic [W-1:0]    rem_ff;
   logic [EW-1:0]   q_ff;
   logic            qhi_ff;

   logic            rsp_valid_ff;
   logic [EW-1:0]   inv_out_ff;
   logic [DW-1:0]   det_out_ff;
   logic            sing_out_ff;
   logic            sat_out_ff;
   logic            last_out_ff;

   logic [EW-1:0]   limb_val;
   logic [2*EW-1:0] pp_in;
   logic [AW-1:0]   horner;
   logic [W-1:0]    acc_ext;
   logic [W-1:0]    sum_mag;
   logic [W-1:0]    qmag_in;
   logic            det_clip;
   logic [W-1:0]    det_lim;
   logic [W-1:0]    det_mag;
   logic [W-1:0]    rem_sh;
   logic            rem_ge;
   logic [EW-1:0]   inv_lim;
   logic            inv_clip;
   logic [EW-1:0]   inv_mag;
   logic [EW-1:0]   inv_val;

   // Write loaded items, read one entry a cycle
   always_ff @(posedge clock) begin
      if (cmd.store_we) store_mem[cmd.wr_addr] <= req_element_value;
      if (cmd.rd_en) rdata_ff <= store_mem[cmd.rd_addr];
   end

   // Arithmetic between registers
   always_comb begin
      limb_val = acc_mag_ff[{cmd.limb, 5'b00000} +: EW];
      pp_in    = limb_val * emag_ff;
      horner   = {prod_ff[AW-EW-1:0], {EW{1'b0}}} + {{(AW-2*EW){1'b0}}, pp_ff};
      acc_ext  = {{(W-AW){1'b0}}, acc_mag_ff};
      sum_mag  = sum_ff[W-1] ? (W'(0) - sum_ff) : sum_ff;
      unique case (cmd.dim)
         3'd1:    qmag_in = dmag_ff << F;
         3'd2:    qmag_in = dmag_ff;
         3'd3:    qmag_in = (dmag_ff + HALF_ONE) >> F;
         3'd4:    qmag_in = (dmag_ff + HALF_TWO) >> (2 * F);
         default: qmag_in = dmag_ff;
      endcase
      det_lim  = dneg_ff ? DET_NEG : DET_POS;
      det_clip = (qmag_ff > det_lim);
      det_mag  = det_clip ? det_lim : qmag_ff;
      rem_sh   = {rem_ff[W-2:0], num_ff[W-1]};
      rem_ge   = (rem_sh >= den_ff);
      inv_lim  = cneg_ff ? INV_NEG : INV_POS;
      inv_clip = qhi_ff || (q_ff > inv_lim);
      inv_mag  = inv_clip ? inv_lim : q_ff;
      inv_val  = cneg_ff ? (EW'(0) - inv_mag) : inv_mag;
   end

   // Form each term: magnitude product and sign
   always_ff @(posedge clock) begin
      if (cmd.acc_init) begin
         acc_mag_ff <= AW'(1);
         acc_neg_ff <= cmd.acc_par;
      end else if (cmd.elem_latch) begin
         acc_neg_ff <= acc_neg_ff ^ rdata_ff[EW-1];
      end else if (cmd.mul_fin) begin
         acc_mag_ff <= horner;
      end
      if (cmd.elem_latch) begin
         emag_ff <= rdata_ff[EW-1] ? (EW'(0) - rdata_ff) : rdata_ff;
         prod_ff <= '0;
      end else if (cmd.mul_prod) begin
         prod_ff <= horner;
      end
      if (cmd.mul_pp) pp_ff <= pp_in;
   end

   // Accumulate signed terms
   always_ff @(posedge clock) begin
      if (cmd.sum_clear) begin
         sum_ff <= '0;
      end else if (cmd.sum_add) begin
         sum_ff <= acc_neg_ff ? (sum_ff - acc_ext) : (sum_ff + acc_ext);
      end
   end

   // Round, test and clip the determinant
   always_ff @(posedge clock) begin
      if (cmd.det_abs) begin
         dneg_ff <= sum_ff[W-1];
         dmag_ff <= sum_mag;
      end
      if (cmd.det_round) qmag_ff <= qmag_in;
      if (cmd.det_sat) begin
         sing_ff    <= (qmag_ff <= {{(W-smi_pkg::THR_W){1'b0}}, threshold});
         dclip_ff   <= det_clip;
         detbits_ff <= dneg_ff ? (DW'(0) - det_mag[DW-1:0]) : det_mag[DW-1:0];
      end
   end

   // Divide the scaled cofactor by the determinant, one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.div_setup) begin
         cneg_ff <= sum_ff[W-1] ^ cmd.cof_par ^ dneg_ff;
         num_ff  <= (sum_mag << (2 * F + 1)) + dmag_ff;
         den_ff  <= dmag_ff << 1;
         rem_ff  <= '0;
         q_ff    <= '0;
         qhi_ff  <= 1'b0;
      end else if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_ge ? (rem_sh - den_ff) : rem_sh;
         q_ff   <= {q_ff[EW-2:0], rem_ge};
         qhi_ff <= qhi_ff | q_ff[EW-1];
      end
   end

   // Hold a result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         inv_out_ff  <= cmd.emit_sing ? '0 : inv_val;
         det_out_ff  <= detbits_ff;
         sing_out_ff <= cmd.emit_sing;
         sat_out_ff  <= cmd.emit_sing ? dclip_ff : (dclip_ff | inv_clip);
         last_out_ff <= cmd.emit_last;
      end
   end

   assign status.sing       = sing_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inverse_value = inv_out_ff;
   assign rsp_determinant   = det_out_ff;
   assign rsp_singular      = sing_out_ff;
   assign rsp_saturated     = sat_out_ff;
   assign rsp_last_result   = last_out_ff;

endmodule

`default_nettype wire

>>> src/small_matrix_inverse_core.sv
// ----------------------------------------------------------------------------
// Small matrix inverse core
// Square matrix inverse, size 1 to 4, by cofactors in exact fixed point.
// ----------------------------------------------------------------------------
// Elements stream in one per cycle, row-major, as signed Q16.16; the size
// comes from the dimension register (0 acts as 1, above 4 acts as 4). When
// the last element lands, the core forms the determinant as a signed sum
// over column permutations, each term built by a 32x32 multiplier that
// works one 32-bit limb per cycle, then emits either one singular result or
// the n*n inverse elements in row-major order, each cofactor divided by a
// restoring divider at one quotient bit per cycle. The divider and the
// shared multiplier set the run time of a matrix. Input stalls while a
// matrix is in work; the final result may still wait in the output register
// while the next matrix loads.
// ----------------------------------------------------------------------------
`default_nettype none

module small_matrix_inverse_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [smi_pkg::ELEM_W-1:0]      req_element_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [smi_pkg::ELEM_W-1:0]      rsp_inverse_value,
   output logic signed [smi_pkg::DET_W-1:0]       rsp_determinant,
   output logic                                   rsp_singular,
   output logic                                   rsp_saturated,
   output logic                                   rsp_last_result,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [smi_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [31:0]                            csr_wdata
);

   logic [smi_pkg::DIM_W-1:0] dimension_ff;
   logic [smi_pkg::THR_W-1:0] threshold_ff;
   logic [smi_pkg::DIM_W-1:0] dim_n;

   smi_pkg::smi_cmd_type    cmd;
   smi_pkg::smi_status_type status;

   // Take register writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= 3'd4;
         threshold_ff <= 32'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            smi_pkg::CSR_DIMENSION: dimension_ff <= csr_wdata[smi_pkg::DIM_W-1:0];
            smi_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the size into range
   always_comb begin
      if (dimension_ff == 3'd0) begin
         dim_n = 3'd1;
      end else if (dimension_ff > smi_pkg::DIM_W'(smi_pkg::MAX_DIM)) begin
         dim_n = smi_pkg::DIM_W'(smi_pkg::MAX_DIM);
      end else begin
         dim_n = dimension_ff;
      end
   end

   smi_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dim_n     (dim_n),
      .status    (status),
      .cmd       (cmd)
   );

   smi_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_element_value (req_element_value),
      .threshold         (threshold_ff),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_inverse_value (rsp_inverse_value),
      .rsp_determinant   (rsp_determinant),
      .rsp_singular      (rsp_singular),
      .rsp_saturated     (rsp_saturated),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

`default_nettype wire

>>> src/smi_checker.sv
// ----------------------------------------------------------------------------
// Small matrix inverse port checker
// Watches the result channel of the core and flags broken results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "small_matrix_inverse_core_defines.svh"

module smi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [smi_pkg::ELEM_W-1:0] rsp_inverse_value,
   input logic signed [smi_pkg::DET_W-1:0]  rsp_determinant,
   input logic                              rsp_singular,
   input logic                              rsp_last_result
);

   // Hold a stalled result
   `SMI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_determinant) && $stable(rsp_inverse_value))

   // A singular result is always marked as the last result
   `SMI_ASSERT_IMPLY(a_sing_last, clock, reset, rsp_valid && rsp_singular, rsp_last_result)

   // A singular result carries no inverse
   `SMI_ASSERT_IMPLY(a_sing_zero, clock, reset, rsp_valid && rsp_singular, rsp_inverse_value == 32'sd0)

endmodule

bind small_matrix_inverse_core smi_checker u_smi_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_inverse_value (rsp_inverse_value),
   .rsp_determinant   (rsp_determinant),
   .rsp_singular      (rsp_singular),
   .rsp_last_result   (rsp_last_result)
);

`default_nettype wire

>>> tb/sv/small_matrix_inverse_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small matrix inverse core testbench
// Streams square matrices of size 1 to 4 into the core and predicts each
// inverse element, determinant and flag with exact wide arithmetic. Each
// result item is checked against the oldest expected one. Directed cases
// cover the extremes and the odd register settings. Random matrices follow
// under bursty input and a shifting output stall pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module small_matrix_inverse_core_tb;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int IDLE_WAIT   = 40;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [31:0] inverse_value;
      logic signed [63:0] determinant;
      logic               singular;
      logic               saturated;
      logic               last_result;
   } inverse_item_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [31:0]            req_element_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [31:0]            rsp_inverse_value;
   logic signed [63:0]            rsp_determinant;
   logic                          rsp_singular;
   logic                          rsp_saturated;
   logic                          rsp_last_result;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [smi_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                   csr_wdata;

   // Predictor copy of the core's state and registers
   logic [31:0]      elem_mem [16];
   int unsigned      loaded_count;
   logic [2:0]       dim_reg;
   logic [31:0]      thr_reg;
   inverse_item_type inverse_expected [$];

   int   error_count;
   int   cycle_count;
   int   burst_left;
   int   stall_left;
   int   stall_mode;

   small_matrix_inverse_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_inverse_value (rsp_inverse_value),
      .rsp_determinant   (rsp_determinant),
      .rsp_singular      (rsp_singular),
      .rsp_saturated     (rsp_saturated),
      .rsp_last_result   (rsp_last_result),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Determinant of the k x k minor picked by row and column lists
   function automatic wide_type minor_det(input longint a [16], input int n,
                                          input int rsel [4], input int csel [4],
                                          input int k);
      wide_type acc;
      wide_type term;
      wide_type elem;
      int       sub [4];
      int       rnext [4];
      int       t;
      acc = 0;
      if (k == 0) return 1;
      for (int i = 0; i < 3; i++) rnext[i] = rsel[i+1];
      rnext[3] = 0;
      for (int j = 0; j < k; j++) begin
         t = 0;
         for (int c = 0; c < 4; c++) sub[c] = 0;
         for (int c = 0; c < k; c++) if (c != j) begin
            sub[t] = csel[c];
            t++;
         end
         elem = wide_type'(a[rsel[0]*n + csel[j]]);
         term = elem * minor_det(a, n, rnext, sub, k - 1);
         if (j % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      return acc;
   endfunction

   // Clip a sign and magnitude to a signed width, flag any clipping
   function automatic logic [63:0] clip_signed(input logic neg, input wide_type mag,
                                               input int width, inout logic clip);
      wide_type lim;
      wide_type v;
      lim = wide_type'(1) <<< (width - 1);
      if (!neg) lim = lim - 1;
      if (mag > lim) begin
         mag  = lim;
         clip = 1'b1;
      end
      v = neg ? -mag : mag;
      return v[63:0];
   endfunction

   // Work out every result of the matrix now complete in the store
   task automatic predict_inverse();
      int               n;
      longint           a [16];
      int               all [4];
      int               rows [4];
      int               cols [4];
      int               t;
      int               u;
      wide_type         det;
      wide_type         dmag;
      wide_type         qmag;
      wide_type         thr;
      wide_type         cof;
      logic             dneg;
      logic             cneg;
      logic             dclip;
      logic             eclip;
      logic [63:0]      detbits;
      logic [63:0]      ebits;
      inverse_item_type item;
      n = (dim_reg == 0) ? 1 : ((dim_reg > 4) ? 4 : int'(dim_reg));
      for (int i = 0; i < 16; i++) a[i] = longint'($signed(elem_mem[i]));
      for (int i = 0; i < 4; i++) all[i] = i;
      det  = minor_det(a, n, all, all, n);
      dneg = det < 0;
      dmag = dneg ? -det : det;
      if (n >= 2) begin
         if (n == 2) qmag = dmag;
         else qmag = (dmag + (wide_type'(1) <<< ((n-2)*16 - 1))) >>> ((n-2)*16);
      end else begin
         qmag = dmag <<< 16;
      end
      thr     = wide_type'(thr_reg);
      dclip   = 1'b0;
      detbits = clip_signed(dneg, qmag, 64, dclip);
      if (qmag <= thr) begin
         item.inverse_value = 0;
         item.determinant   = detbits;
         item.singular      = 1'b1;
         item.saturated     = dclip;
         item.last_result   = 1'b1;
         inverse_expected.push_back(item);
         return;
      end
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            t = 0;
            u = 0;
            for (int i = 0; i < 4; i++) begin
               rows[i] = 0;
               cols[i] = 0;
            end
            for (int i = 0; i < n; i++) begin
               if (i != c) begin
                  rows[t] = i;
                  t++;
               end
               if (i != r) begin
                  cols[u] = i;
                  u++;
               end
            end
            cof = minor_det(a, n, rows, cols, n - 1);
            if ((r + c) % 2 == 1) cof = -cof;
            cneg  = cof < 0;
            cof   = (cneg ? -cof : cof) <<< 32;
            cof   = ((cof <<< 1) + dmag) / (dmag <<< 1);
            eclip = dclip;
            ebits = clip_signed(cneg != dneg, cof, 32, eclip);
            item.inverse_value = ebits[31:0];
            item.determinant   = detbits;
            item.singular      = 1'b0;
            item.saturated     = eclip;
            item.last_result   = (r == n - 1) && (c == n - 1);
            inverse_expected.push_back(item);
         end
      end
   endtask

   // Track one accepted element in the predictor
   task automatic load_element(input logic [31:0] v);
      int n;
      n = (dim_reg == 0) ? 1 : ((dim_reg > 4) ? 4 : int'(dim_reg));
      elem_mem[loaded_count % 16] = v;
      loaded_count = (loaded_count + 1) % 32;
      if (loaded_count >= n * n) begin
         loaded_count = 0;
         predict_inverse();
      end
   endtask

   // Send one element; open a new burst after a random gap when one runs out
   task automatic send_element(input logic [31:0] v);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_element_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      load_element(v);
      burst_left--;
   endtask

   task automatic release_input();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   // Hold until every expected item has come, then let the core settle
   task automatic drain_results();
      release_input();
      while (inverse_expected.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [smi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == smi_pkg::CSR_DIMENSION) dim_reg = data[2:0];
      else if (idx == smi_pkg::CSR_THRESHOLD) thr_reg = data;
      @(posedge clock);
   endtask

   // Build one matrix of the given style and stream it in
   task automatic send_matrix(input int n, input int style);
      logic [31:0] m [16];
      for (int i = 0; i < n * n; i++) begin
         unique case (style)
            0: m[i] = $urandom;
            1: m[i] = $urandom_range(0, 8 * 65536) - 4 * 65536;
            2: m[i] = ((i / n == i % n) ? 32'h0001_0000 : 32'h0) +
                      $urandom_range(0, 511) - 256;
            default: m[i] = $urandom_range(0, 6 * 65536) - 3 * 65536;
         endcase
      end
      // Repeat the first row at the bottom to force a zero determinant
      if (style == 3 && n > 1)
         for (int c = 0; c < n; c++) m[(n-1)*n + c] = m[c];
      for (int i = 0; i < n * n; i++) send_element(m[i]);
   endtask

   // Extremes of a 1x1 inverse, then size 0, then 2x2 matrices under a full and a low threshold
   task automatic test_directed_extremes();
      write_csr(smi_pkg::CSR_THRESHOLD, 32'd0);
      write_csr(smi_pkg::CSR_DIMENSION, 32'd1);
      send_element(32'h0000_0000);
      send_element(32'h0001_0000);
      send_element(32'hFFFF_0000);
      send_element(32'h8000_0000);
      send_element(32'h7FFF_FFFF);
      send_element(32'h0000_0001);
      send_element(32'hFFFF_FFFF);
      drain_results();
      write_csr(smi_pkg::CSR_DIMENSION, 32'd0);
      send_element(32'h0002_0000);
      drain_results();
      write_csr(smi_pkg::CSR_THRESHOLD, 32'hFFFF_FFFF);
      write_csr(smi_pkg::CSR_DIMENSION, 32'd2);
      send_element(32'h0001_0000);
      send_element(32'h0000_0000);
      send_element(32'h0000_0000);
      send_element(32'h0001_0000);
      drain_results();
      write_csr(smi_pkg::CSR_THRESHOLD, 32'd1);
      send_element(32'h8000_0000);
      send_element(32'h7FFF_FFFF);
      send_element(32'h7FFF_FFFF);
      send_element(32'h8000_0000);
      drain_results();
   endtask

   // Shrink the size partway through a load
   task automatic test_resize_mid_load();
      write_csr(smi_pkg::CSR_DIMENSION, 32'd3);
      send_element(32'h0003_0000);
      send_element(32'h1234_5678);
      drain_results();
      write_csr(smi_pkg::CSR_DIMENSION, 32'd1);
      send_element(32'hDEAD_BEEF);
      drain_results();
   endtask

   // Random matrices of one size under one threshold
   task automatic test_random_size(input logic [2:0] dim_code, input int n,
                                   input int count, input logic [31:0] thr);
      write_csr(smi_pkg::CSR_DIMENSION, {29'd0, dim_code});
      write_csr(smi_pkg::CSR_THRESHOLD, thr);
      for (int k = 0; k < count; k++) begin
         send_matrix(n, $urandom_range(0, 3));
         // Starve the input once until all results are out
         if (k == count / 2) begin
            release_input();
            while (inverse_expected.size() != 0) @(posedge clock);
         end
      end
      drain_results();
   endtask

   // Compare each accepted result with the oldest expected item
   always @(posedge clock) begin
      inverse_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inverse_expected.size() == 0) begin
            $display("%0t: unexpected result inverse=%h det=%h", $time,
                     rsp_inverse_value, rsp_determinant);
            error_count++;
         end else begin
            e = inverse_expected.pop_front();
            if (rsp_inverse_value !== e.inverse_value) begin
               $display("%0t: inverse_value expected %h actual %h", $time,
                        e.inverse_value, rsp_inverse_value);
               error_count++;
            end
            if (rsp_determinant !== e.determinant) begin
               $display("%0t: determinant expected %h actual %h", $time,
                        e.determinant, rsp_determinant);
               error_count++;
            end
            if (rsp_singular !== e.singular) begin
               $display("%0t: singular expected %b actual %b", $time,
                        e.singular, rsp_singular);
               error_count++;
            end
            if (rsp_saturated !== e.saturated) begin
               $display("%0t: saturated expected %b actual %b", $time,
                        e.saturated, rsp_saturated);
               error_count++;
            end
            if (rsp_last_result !== e.last_result) begin
               $display("%0t: last_result expected %b actual %b", $time,
                        e.last_result, rsp_last_result);
               error_count++;
            end
         end
      end
   end

   // Output stall: switch among patterns at random intervals
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         stall_mode <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 300);
         end else begin
            stall_left <= stall_left - 1;
         end
         unique case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= $urandom_range(0, 1);
            2:       rsp_stall <= ($urandom_range(0, 7) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_element_value <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      error_count  = 0;
      burst_left   = 0;
      loaded_count = 0;
      dim_reg      = 3'd4;
      thr_reg      = 32'd1;
      for (int i = 0; i < 16; i++) elem_mem[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (IDLE_WAIT) @(posedge clock);

      test_directed_extremes();
      test_resize_mid_load();
      test_random_size(3'd1, 1, 60, $urandom);
      test_random_size(3'd2, 2, 20, 32'hFFFF_FFFF);
      test_random_size(3'd2, 2, 16, 32'd0);
      test_random_size(3'd3, 3, 12, $urandom_range(0, 65535));
      test_random_size(3'd7, 4, 2, 32'd1);
      test_random_size(3'd4, 4, 2, $urandom);

      drain_results();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> small_matrix_inverse_core.f
+incdir+src
src/smi_pkg.sv
src/smi_controller.sv
src/smi_datapath.sv
src/small_matrix_inverse_core.sv
src/smi_checker.sv
tb/sv/small_matrix_inverse_core_tb.sv
